@@ rtl/core/tovl_pkg.sv @@
// Shared types, constants and the 5x7 font table of the text overlay pixel generator.
// Self-contained; the stage modules, the top level and the bench refer to it by scoped names.
package tovl_pkg;

    localparam int DEF_IMAGE_WIDTH = 240;
    localparam int DEF_LINE_CHARS  = 27;
    localparam int DEF_TEXT_LINES  = 7;

    localparam int PANEL_W = 320;
    localparam int PANEL_H = 240;
    localparam int TEXT_X0 = 12;
    localparam int PITCH   = 6;
    localparam int GLYPH_W = 5;

    // Highest character slot whose glyph still ends inside the panel, per scale.
    localparam int KMAX_SCALE2 = (PANEL_W - TEXT_X0 - 2 * GLYPH_W) / (2 * PITCH);
    localparam int KMAX_SCALE1 = (PANEL_W - TEXT_X0 - GLYPH_W) / PITCH;

    localparam logic [7:0] LINE_TOP [7] = '{8'd10, 8'd48, 8'd78, 8'd108, 8'd138, 8'd168,
                                            8'd220};

    localparam logic [15:0] RESET_BACKGROUND = 16'h18E3;
    localparam logic [15:0] RESET_MARGIN     = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_WRITE_CELL = 2'd0,
        OP_SET_LINE   = 2'd1,
        OP_PIXEL      = 2'd2,
        OP_IDLE       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_PAGE_SELECT = 2'd0,
        CFG_BACKGROUND  = 2'd1,
        CFG_MARGIN      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic        page_select;
        logic [15:0] background_color;
        logic [15:0] margin_color;
    } cfg_t;

    // After line and window lookup.
    typedef struct packed {
        op_t         op;
        logic [2:0]  line;
        logic [4:0]  pos;
        logic [6:0]  code;
        logic [4:0]  len;
        logic [15:0] color;
        logic        text_hit;
        logic        scale2;
        logic [2:0]  frow;
        logic [8:0]  dx;
        logic        win;
        logic [7:0]  row;
        logic [8:0]  offset;
    } s1_t;

    // After the character slot division and the image row product.
    typedef struct packed {
        op_t         op;
        logic [2:0]  line;
        logic [4:0]  pos;
        logic [6:0]  code;
        logic [4:0]  len;
        logic [15:0] color;
        logic        text_ok;
        logic [2:0]  frow;
        logic [6:0]  k;
        logic [2:0]  fcol;
        logic        win;
        logic [16:0] prod;
        logic [8:0]  offset;
    } s2_t;

    // After the character store read.
    typedef struct packed {
        op_t         op;
        logic        draw;
        logic [2:0]  fcol;
        logic [2:0]  frow;
        logic [15:0] line_color;
        logic        win;
        logic [15:0] image_addr;
    } s3_t;

    typedef logic [4:0][6:0] glyph_t;

    function automatic glyph_t glyph5(input logic [6:0] c0, input logic [6:0] c1,
                                      input logic [6:0] c2, input logic [6:0] c3,
                                      input logic [6:0] c4);
        glyph5 = {c4, c3, c2, c1, c0};
    endfunction

    // Column bitmaps, bit 0 at the top row. Space and unknown codes are blank.
    function automatic glyph_t font_glyph(input logic [6:0] code);
        glyph_t g;
        unique case (code)
            7'd45: g = glyph5(7'h08, 7'h08, 7'h08, 7'h08, 7'h08);
            7'd46: g = glyph5(7'h00, 7'h60, 7'h60, 7'h00, 7'h00);
            7'd58: g = glyph5(7'h00, 7'h36, 7'h36, 7'h00, 7'h00);
            7'd48: g = glyph5(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
            7'd49: g = glyph5(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
            7'd50: g = glyph5(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
            7'd51: g = glyph5(7'h21, 7'h41, 7'h45, 7'h4B, 7'h31);
            7'd52: g = glyph5(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
            7'd53: g = glyph5(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
            7'd54: g = glyph5(7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30);
            7'd55: g = glyph5(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
            7'd56: g = glyph5(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
            7'd57: g = glyph5(7'h06, 7'h49, 7'h49, 7'h29, 7'h1E);
            7'd65: g = glyph5(7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E);
            7'd66: g = glyph5(7'h7F, 7'h49, 7'h49, 7'h49, 7'h36);
            7'd67: g = glyph5(7'h3E, 7'h41, 7'h41, 7'h41, 7'h22);
            7'd68: g = glyph5(7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C);
            7'd69: g = glyph5(7'h7F, 7'h49, 7'h49, 7'h49, 7'h41);
            7'd70: g = glyph5(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01);
            7'd71: g = glyph5(7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A);
            7'd72: g = glyph5(7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F);
            7'd73: g = glyph5(7'h00, 7'h41, 7'h7F, 7'h41, 7'h00);
            7'd74: g = glyph5(7'h20, 7'h40, 7'h41, 7'h3F, 7'h01);
            7'd75: g = glyph5(7'h7F, 7'h08, 7'h14, 7'h22, 7'h41);
            7'd76: g = glyph5(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
            7'd77: g = glyph5(7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F);
            7'd78: g = glyph5(7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F);
            7'd79: g = glyph5(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E);
            7'd80: g = glyph5(7'h7F, 7'h09, 7'h09, 7'h09, 7'h06);
            7'd81: g = glyph5(7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E);
            7'd82: g = glyph5(7'h7F, 7'h09, 7'h19, 7'h29, 7'h46);
            7'd83: g = glyph5(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
            7'd84: g = glyph5(7'h01, 7'h01, 7'h7F, 7'h01, 7'h01);
            7'd85: g = glyph5(7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F);
            7'd86: g = glyph5(7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F);
            7'd87: g = glyph5(7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F);
            7'd88: g = glyph5(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
            7'd89: g = glyph5(7'h07, 7'h08, 7'h70, 7'h08, 7'h07);
            7'd90: g = glyph5(7'h61, 7'h51, 7'h49, 7'h45, 7'h43);
            default: g = '0;
        endcase
        font_glyph = g;
    endfunction

endpackage

@@ rtl/core/tovl_req_if.sv @@
// Request channel of the text overlay pixel generator: valid, ready and one input item.
// Stands alone; the opcode is decoded against tovl_pkg by the modules that sink it.
interface tovl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [2:0]  line_index;
    logic [4:0]  char_position;
    logic [6:0]  char_code;
    logic [4:0]  line_length;
    logic [15:0] line_color;
    logic [7:0]  pixel_row;
    logic [8:0]  pixel_column;

    modport source (output valid, opcode, line_index, char_position, char_code, line_length,
                    line_color, pixel_row, pixel_column, input ready);
    modport sink (input valid, opcode, line_index, char_position, char_code, line_length,
                  line_color, pixel_row, pixel_column, output ready);
endinterface

@@ rtl/core/tovl_rsp_if.sv @@
// Result channel of the text overlay pixel generator: valid, ready and one result item.
// Stands alone.
interface tovl_rsp_if;
    logic        valid;
    logic        ready;
    logic        pixel_valid;
    logic [15:0] pixel_color;
    logic        use_image;
    logic [15:0] image_address;

    modport source (output valid, pixel_valid, pixel_color, use_image, image_address,
                    input ready);
    modport sink (input valid, pixel_valid, pixel_color, use_image, image_address,
                  output ready);
endinterface

@@ rtl/core/tovl_locate.sv @@
// First pipeline stage: finds the text line under the pixel row and the cover image window.
// Uses tovl_pkg and sinks tovl_req_if.
module tovl_locate #(
    parameter int TEXT_LINES  = tovl_pkg::DEF_TEXT_LINES,
    parameter int IMAGE_WIDTH = tovl_pkg::DEF_IMAGE_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    tovl_req_if.sink      request,
    output logic          out_valid,
    input  logic          out_ready,
    output tovl_pkg::s1_t out_data
);

    localparam int WIN_START = (tovl_pkg::PANEL_W - IMAGE_WIDTH) / 2;

    logic          valid_reg;
    logic          load;
    tovl_pkg::s1_t data_reg;
    tovl_pkg::s1_t data_next;

    assign load          = !valid_reg || out_ready;
    assign request.ready = load;
    assign out_valid     = valid_reg;
    assign out_data      = data_reg;

    always_comb
    begin
        logic       hit;
        logic [2:0] hit_line;
        logic       sc2;
        logic [2:0] frow;
        logic [7:0] rel;
        logic       two;
        logic [8:0] bottom;

        hit      = 1'b0;
        hit_line = '0;
        sc2      = 1'b0;
        frow     = '0;
        rel      = '0;
        two      = 1'b0;
        bottom   = '0;
        // Line tops are far enough apart that at most one line covers a row;
        // the loop still lets a later line win.
        for (int l = 0; l < TEXT_LINES; l++)
        begin
            two    = (l != TEXT_LINES - 1);
            bottom = {1'b0, tovl_pkg::LINE_TOP[l]} + (two ? 9'd14 : 9'd7);
            rel    = request.pixel_row - tovl_pkg::LINE_TOP[l];
            if (request.pixel_row >= tovl_pkg::LINE_TOP[l] && {1'b0, request.pixel_row} < bottom)
            begin
                hit      = 1'b1;
                hit_line = 3'(l);
                sc2      = two;
                frow     = two ? rel[3:1] : rel[2:0];
            end
        end

        data_next.op       = tovl_pkg::op_t'(request.opcode);
        data_next.line     = (tovl_pkg::op_t'(request.opcode) == tovl_pkg::OP_PIXEL)
                             ? hit_line : request.line_index;
        data_next.pos      = request.char_position;
        data_next.code     = request.char_code;
        data_next.len      = request.line_length;
        data_next.color    = request.line_color;
        data_next.text_hit = hit && (request.pixel_column >= 9'(tovl_pkg::TEXT_X0));
        data_next.scale2   = sc2;
        data_next.frow     = frow;
        data_next.dx       = request.pixel_column - 9'(tovl_pkg::TEXT_X0);
        data_next.win      = ({1'b0, request.pixel_row} < 9'(tovl_pkg::PANEL_H))
                             && ({1'b0, request.pixel_column} >= 10'(WIN_START))
                             && ({1'b0, request.pixel_column} < 10'(WIN_START + IMAGE_WIDTH));
        data_next.row      = request.pixel_row;
        data_next.offset   = request.pixel_column - 9'(WIN_START);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && request.valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/core/tovl_divide.sv @@
// Second pipeline stage: splits the text x offset into character slot and glyph column,
// and forms the image row product. Uses tovl_pkg.
module tovl_divide #(
    parameter int IMAGE_WIDTH = tovl_pkg::DEF_IMAGE_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tovl_pkg::s1_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output tovl_pkg::s2_t out_data
);

    logic          valid_reg;
    logic          load;
    tovl_pkg::s2_t data_reg;
    tovl_pkg::s2_t data_next;

    assign load      = !valid_reg || out_ready;
    assign in_ready  = load;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Remainder by three of a value of at most twelve.
    function automatic logic [1:0] mod3_small(input logic [3:0] s);
        logic [1:0] r;
        unique case (s)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
            4'd2, 4'd5, 4'd8, 4'd11:       r = 2'd2;
            default:                       r = 2'd0;
        endcase
        mod3_small = r;
    endfunction

    always_comb
    begin
        logic [7:0]  v;
        logic [15:0] qprod;
        logic [6:0]  q;
        logic [3:0]  dsum;
        logic [1:0]  r;
        logic        b;
        logic [2:0]  c;
        logic        k_fits;

        // The slot pitch is 6 or 12 pixels, so the low dx bits drop off and the rest
        // is divided by three: floor(v * 171 / 512) is exact below 512.
        v      = in_data.scale2 ? {1'b0, in_data.dx[8:2]} : in_data.dx[8:1];
        b      = in_data.scale2 ? in_data.dx[1] : in_data.dx[0];
        qprod  = {8'd0, v} * 16'd171;
        q      = qprod[15:9];
        // Base-four digits sum to the same residue modulo three.
        dsum   = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        r      = mod3_small(dsum);
        c      = {r, b};
        k_fits = in_data.scale2 ? (q <= 7'(tovl_pkg::KMAX_SCALE2))
                                : (q <= 7'(tovl_pkg::KMAX_SCALE1));

        data_next.op      = in_data.op;
        data_next.line    = in_data.line;
        data_next.pos     = in_data.pos;
        data_next.code    = in_data.code;
        data_next.len     = in_data.len;
        data_next.color   = in_data.color;
        data_next.text_ok = in_data.text_hit && (c < 3'd5) && k_fits;
        data_next.frow    = in_data.frow;
        data_next.k       = q;
        data_next.fcol    = c;
        data_next.win     = in_data.win;
        data_next.prod    = 17'(in_data.row) * 17'(IMAGE_WIDTH);
        data_next.offset  = in_data.offset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/core/tovl_fetch.sv @@
// Third pipeline stage: holds the character store and the per-line length and colour,
// applies writes and reads the character under the pixel. Uses tovl_pkg.
module tovl_fetch #(
    parameter int LINE_CHARS = tovl_pkg::DEF_LINE_CHARS,
    parameter int TEXT_LINES = tovl_pkg::DEF_TEXT_LINES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tovl_pkg::s2_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output tovl_pkg::s3_t out_data,
    output logic [6:0]    out_code
);

    localparam int CELLS  = TEXT_LINES * LINE_CHARS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LINE_W = (TEXT_LINES > 1) ? $clog2(TEXT_LINES) : 1;

    logic              valid_reg;
    logic              load;
    tovl_pkg::s3_t     data_reg;
    tovl_pkg::s3_t     data_next;
    logic [6:0]        code_reg;
    logic [6:0]        cells [CELLS];
    logic [4:0]        len_reg [TEXT_LINES];
    logic [15:0]       color_reg [TEXT_LINES];
    logic [6:0]        sel_pos;
    logic [9:0]        addr_full;
    logic [ADDR_W-1:0] addr;
    logic [LINE_W-1:0] line_idx;
    logic              line_in_range;
    logic              write_cell;
    logic              write_line;

    assign load      = !valid_reg || out_ready;
    assign in_ready  = load;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_code  = code_reg;

    // One address serves the cell write and the pixel read; an item is only one of them.
    assign sel_pos       = (in_data.op == tovl_pkg::OP_WRITE_CELL) ? {2'b00, in_data.pos}
                                                                   : in_data.k;
    assign addr_full     = 10'(in_data.line) * 10'(LINE_CHARS) + 10'(sel_pos);
    assign addr          = addr_full[ADDR_W-1:0];
    assign line_idx      = in_data.line[LINE_W-1:0];
    assign line_in_range = {1'b0, in_data.line} < 4'(TEXT_LINES);

    assign write_cell = load && in_valid && (in_data.op == tovl_pkg::OP_WRITE_CELL)
                        && line_in_range && ({1'b0, in_data.pos} < 6'(LINE_CHARS));
    assign write_line = load && in_valid && (in_data.op == tovl_pkg::OP_SET_LINE)
                        && line_in_range;

    always_ff @(posedge clk)
    begin
        if (write_cell)
        begin
            cells[addr] <= in_data.code;
        end
        if (load)
        begin
            code_reg <= cells[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TEXT_LINES; i++)
            begin
                len_reg[i]   <= '0;
                color_reg[i] <= '0;
            end
        end
        else if (write_line)
        begin
            len_reg[line_idx]   <= in_data.len;
            color_reg[line_idx] <= in_data.color;
        end
    end

    always_comb
    begin
        data_next.op         = in_data.op;
        data_next.draw       = in_data.text_ok && (in_data.k < {2'b00, len_reg[line_idx]})
                               && (in_data.k < 7'(LINE_CHARS));
        data_next.fcol       = in_data.fcol;
        data_next.frow       = in_data.frow;
        data_next.line_color = color_reg[line_idx];
        data_next.win        = in_data.win;
        data_next.image_addr = 16'(in_data.prod + 17'(in_data.offset));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/core/tovl_shade.sv @@
// Last pipeline stage: font lookup, page selection and the result output register.
// Uses tovl_pkg and drives tovl_rsp_if.
module tovl_shade (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tovl_pkg::s3_t  in_data,
    input  logic [6:0]     in_code,
    input  tovl_pkg::cfg_t cfg,
    tovl_rsp_if.source     result
);

    logic                 valid_reg;
    logic                 load;
    logic                 pixel_valid_reg;
    logic [15:0]          pixel_color_reg;
    logic                 use_image_reg;
    logic [15:0]          image_address_reg;
    logic                 pixel_valid_next;
    logic [15:0]          pixel_color_next;
    logic                 use_image_next;
    logic [15:0]          image_address_next;
    tovl_pkg::glyph_t     glyph;
    logic                 lit;

    assign load                 = !valid_reg || result.ready;
    assign in_ready             = load;
    assign result.valid         = valid_reg;
    assign result.pixel_valid   = pixel_valid_reg;
    assign result.pixel_color   = pixel_color_reg;
    assign result.use_image     = use_image_reg;
    assign result.image_address = image_address_reg;

    assign glyph = tovl_pkg::font_glyph(in_code);
    assign lit   = in_data.draw && glyph[in_data.fcol][in_data.frow];

    always_comb
    begin
        pixel_valid_next   = 1'b0;
        pixel_color_next   = '0;
        use_image_next     = 1'b0;
        image_address_next = '0;
        // Writes and the unused opcode are acknowledged with all fields zero.
        if (in_data.op == tovl_pkg::OP_PIXEL)
        begin
            pixel_valid_next = 1'b1;
            if (cfg.page_select)
            begin
                pixel_color_next = lit ? in_data.line_color : cfg.background_color;
            end
            else if (in_data.win)
            begin
                use_image_next     = 1'b1;
                image_address_next = in_data.image_addr;
            end
            else
            begin
                pixel_color_next = cfg.margin_color;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            pixel_valid_reg   <= pixel_valid_next;
            pixel_color_reg   <= pixel_color_next;
            use_image_reg     <= use_image_next;
            image_address_reg <= image_address_next;
        end
    end

endmodule

@@ rtl/core/text_overlay_pixel_generator.sv @@
// Top level of the text overlay pixel generator: configuration registers and four stages.
// Uses tovl_pkg, tovl_req_if, tovl_rsp_if and the tovl stage modules.
//
// The block takes one transaction per clock on the request channel unless the result channel
// stalls, a rate set by the single-port character store, which is written and read in the same
// stage so a pixel sees every write accepted before it. It returns exactly one result for each,
// in order: a pixel colour, an image window flag with address, or a zero acknowledge for cell
// writes, line settings and the unused opcode. Results pass four registered stages: line
// lookup, slot division, character store read, and font lookup with the output register. Stages
// hold independently, so bubbles close up while the result channel stalls. The character store
// has no reset; reading an unwritten cell gives an undefined glyph. Configuration is written
// through cfg_we, cfg_index and cfg_data; the user must do so only while no transaction is in
// flight; the block does not enforce it. Indexes beyond the register list are ignored.
module text_overlay_pixel_generator #(
    parameter int IMAGE_WIDTH = tovl_pkg::DEF_IMAGE_WIDTH,
    parameter int LINE_CHARS  = tovl_pkg::DEF_LINE_CHARS,
    parameter int TEXT_LINES  = tovl_pkg::DEF_TEXT_LINES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    tovl_req_if.sink    request,
    tovl_rsp_if.source  result
);

    tovl_pkg::cfg_t cfg_reg;
    tovl_pkg::s1_t  s1_data;
    tovl_pkg::s2_t  s2_data;
    tovl_pkg::s3_t  s3_data;
    logic [6:0]     s3_code;
    logic           s1_valid;
    logic           s1_ready;
    logic           s2_valid;
    logic           s2_ready;
    logic           s3_valid;
    logic           s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_select      <= 1'b0;
            cfg_reg.background_color <= tovl_pkg::RESET_BACKGROUND;
            cfg_reg.margin_color     <= tovl_pkg::RESET_MARGIN;
        end
        else if (cfg_we)
        begin
            unique case (tovl_pkg::cfg_reg_t'(cfg_index))
                tovl_pkg::CFG_PAGE_SELECT: cfg_reg.page_select      <= cfg_data[0];
                tovl_pkg::CFG_BACKGROUND:  cfg_reg.background_color <= cfg_data;
                tovl_pkg::CFG_MARGIN:      cfg_reg.margin_color     <= cfg_data;
                default:                   ;
            endcase
        end
    end

    tovl_locate #(
        .TEXT_LINES  (TEXT_LINES),
        .IMAGE_WIDTH (IMAGE_WIDTH)
    ) u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    tovl_divide #(
        .IMAGE_WIDTH (IMAGE_WIDTH)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    tovl_fetch #(
        .LINE_CHARS (LINE_CHARS),
        .TEXT_LINES (TEXT_LINES)
    ) u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data),
        .out_code  (s3_code)
    );

    tovl_shade u_shade (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s3_valid),
        .in_ready (s3_ready),
        .in_data  (s3_data),
        .in_code  (s3_code),
        .cfg      (cfg_reg),
        .result   (result)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for text_overlay_pixel_generator: directed and random request streams with random
// stalls on both channels, each result checked against an in-bench model of the pixel logic.
// Depends on tovl_pkg, tovl_req_if, tovl_rsp_if and the block's RTL.
module tb_top;

    localparam int CLK_HALF     = 6;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_LINES      = 7;
    localparam int N_CHARS      = 27;
    localparam int IMG_W        = 240;
    localparam int IMG_X0       = 40;
    localparam int SCREEN_W     = 320;
    localparam int SCREEN_H     = 240;
    localparam int TEXT_LEFT    = 12;

    typedef struct packed {
        logic        pixel_valid;
        logic [15:0] color;
        logic        use_image;
        logic [15:0] address;
    } pixel_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'b00;
    logic [15:0] cfg_data = 16'h0000;

    tovl_req_if request_ch();
    tovl_rsp_if result_ch();

    text_overlay_pixel_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request_ch),
        .result    (result_ch)
    );

    // Shadow copy of the block's stores and registers.
    logic [6:0]  cell_mem [N_LINES][N_CHARS];
    logic [4:0]  line_len [N_LINES];
    logic [15:0] line_rgb [N_LINES];
    logic        page_sel;
    logic [15:0] back_rgb;
    logic [15:0] margin_rgb;

    pixel_result_t expected_pixels [$];
    int            mismatches = 0;
    int            idle_cycles = 0;
    bit            calm_mode = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int text_top(input int ln);
        case (ln)
            0: return 10;
            1: return 48;
            2: return 78;
            3: return 108;
            4: return 138;
            5: return 168;
            default: return 220;
        endcase
    endfunction

    // Five font columns packed as bytes, leftmost column in the top byte, bit 0 is the top row.
    function automatic logic [39:0] font_columns(input logic [6:0] code);
        case (code)
            7'd45: return 40'h08_08_08_08_08;
            7'd46: return 40'h00_60_60_00_00;
            7'd58: return 40'h00_36_36_00_00;
            7'd48: return 40'h3E_51_49_45_3E;
            7'd49: return 40'h00_42_7F_40_00;
            7'd50: return 40'h42_61_51_49_46;
            7'd51: return 40'h21_41_45_4B_31;
            7'd52: return 40'h18_14_12_7F_10;
            7'd53: return 40'h27_45_45_45_39;
            7'd54: return 40'h3C_4A_49_49_30;
            7'd55: return 40'h01_71_09_05_03;
            7'd56: return 40'h36_49_49_49_36;
            7'd57: return 40'h06_49_49_29_1E;
            7'd65: return 40'h7E_11_11_11_7E;
            7'd66: return 40'h7F_49_49_49_36;
            7'd67: return 40'h3E_41_41_41_22;
            7'd68: return 40'h7F_41_41_22_1C;
            7'd69: return 40'h7F_49_49_49_41;
            7'd70: return 40'h7F_09_09_09_01;
            7'd71: return 40'h3E_41_49_49_7A;
            7'd72: return 40'h7F_08_08_08_7F;
            7'd73: return 40'h00_41_7F_41_00;
            7'd74: return 40'h20_40_41_3F_01;
            7'd75: return 40'h7F_08_14_22_41;
            7'd76: return 40'h7F_40_40_40_40;
            7'd77: return 40'h7F_02_0C_02_7F;
            7'd78: return 40'h7F_04_08_10_7F;
            7'd79: return 40'h3E_41_41_41_3E;
            7'd80: return 40'h7F_09_09_09_06;
            7'd81: return 40'h3E_41_51_21_5E;
            7'd82: return 40'h7F_09_19_29_46;
            7'd83: return 40'h46_49_49_49_31;
            7'd84: return 40'h01_01_7F_01_01;
            7'd85: return 40'h3F_40_40_40_3F;
            7'd86: return 40'h1F_20_40_20_1F;
            7'd87: return 40'h3F_40_38_40_3F;
            7'd88: return 40'h63_14_08_14_63;
            7'd89: return 40'h07_08_70_08_07;
            7'd90: return 40'h61_51_49_45_43;
            default: return 40'h0;
        endcase
    endfunction

    function automatic logic [15:0] status_color(input int row, input int col);
        logic [15:0] rgb;
        logic [39:0] glyph;
        int          s;
        int          top;
        int          frow;
        int          dx;
        int          k;
        int          fc;
        int          len;
        rgb = back_rgb;
        for (int ln = 0; ln < N_LINES; ln++)
        begin
            s = (ln == N_LINES - 1) ? 1 : 2;
            top = text_top(ln);
            if (row < top || row >= top + 7 * s || col < TEXT_LEFT)
                continue;
            frow = (row - top) / s;
            dx = col - TEXT_LEFT;
            k = dx / (6 * s);
            fc = (dx % (6 * s)) / s;
            len = line_len[ln];
            if (len > N_CHARS)
                len = N_CHARS;
            if (fc >= 5 || k >= len)
                continue;
            // A glyph that would run past the right edge of the panel is dropped whole.
            if (TEXT_LEFT + 6 * s * k + 5 * s > SCREEN_W)
                continue;
            glyph = font_columns(cell_mem[ln][k]);
            if (glyph[8 * (4 - fc) + frow])
                rgb = line_rgb[ln];
        end
        return rgb;
    endfunction

    // Applies one request transaction to the shadow state and returns the result it must cause.
    function automatic pixel_result_t predict_pixel_result(
        input tovl_pkg::op_t op, input logic [2:0] li, input logic [4:0] cp,
        input logic [6:0] code, input logic [4:0] len, input logic [15:0] rgb,
        input logic [7:0] row, input logic [8:0] col);
        pixel_result_t r;
        int            row_i;
        int            col_i;
        int            addr;
        r = '0;
        row_i = row;
        col_i = col;
        case (op)
            tovl_pkg::OP_WRITE_CELL:
            begin
                if (li < N_LINES && cp < N_CHARS)
                    cell_mem[li][cp] = code;
            end
            tovl_pkg::OP_SET_LINE:
            begin
                if (li < N_LINES)
                begin
                    line_len[li] = len;
                    line_rgb[li] = rgb;
                end
            end
            tovl_pkg::OP_PIXEL:
            begin
                r.pixel_valid = 1'b1;
                if (page_sel)
                    r.color = status_color(row_i, col_i);
                else if (row_i < SCREEN_H && col_i >= IMG_X0 && col_i < IMG_X0 + IMG_W)
                begin
                    addr = row_i * IMG_W + (col_i - IMG_X0);
                    r.use_image = 1'b1;
                    r.address = addr[15:0];
                end
                else
                    r.color = margin_rgb;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [6:0] random_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 7'($urandom_range(65, 90));
        if (r < 6)
            return 7'($urandom_range(48, 57));
        if (r == 6)
        begin
            case ($urandom_range(0, 3))
                0: return 7'd32;
                1: return 7'd45;
                2: return 7'd46;
                default: return 7'd58;
            endcase
        end
        return 7'($urandom);
    endfunction

    task automatic send_item(input tovl_pkg::op_t op, input logic [2:0] li,
                             input logic [4:0] cp, input logic [6:0] code,
                             input logic [4:0] len, input logic [15:0] rgb,
                             input logic [7:0] row, input logic [8:0] col);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            request_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        request_ch.valid         <= 1'b1;
        request_ch.opcode        <= op;
        request_ch.line_index    <= li;
        request_ch.char_position <= cp;
        request_ch.char_code     <= code;
        request_ch.line_length   <= len;
        request_ch.line_color    <= rgb;
        request_ch.pixel_row     <= row;
        request_ch.pixel_column  <= col;
        do
            @(posedge clk);
        while (request_ch.ready !== 1'b1);
        expected_pixels.push_back(predict_pixel_result(op, li, cp, code, len, rgb, row, col));
    endtask

    // Fields that an opcode does not use carry random values.
    task automatic send_cell(input logic [2:0] li, input logic [4:0] cp, input logic [6:0] code);
        send_item(tovl_pkg::OP_WRITE_CELL, li, cp, code, 5'($urandom), 16'($urandom),
                  8'($urandom), 9'($urandom));
    endtask

    task automatic send_line(input logic [2:0] li, input logic [4:0] len, input logic [15:0] rgb);
        send_item(tovl_pkg::OP_SET_LINE, li, 5'($urandom), 7'($urandom), len, rgb,
                  8'($urandom), 9'($urandom));
    endtask

    task automatic send_pixel(input logic [7:0] row, input logic [8:0] col);
        send_item(tovl_pkg::OP_PIXEL, 3'($urandom), 5'($urandom), 7'($urandom), 5'($urandom),
                  16'($urandom), row, col);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        request_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input tovl_pkg::cfg_reg_t idx, input logic [15:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            tovl_pkg::CFG_PAGE_SELECT: page_sel = value[0];
            tovl_pkg::CFG_BACKGROUND:  back_rgb = value;
            tovl_pkg::CFG_MARGIN:      margin_rgb = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic send_random_item();
        int          pick;
        int          ln;
        int          s;
        logic [2:0]  li;
        logic [4:0]  cp;
        logic [4:0]  len;
        logic [7:0]  row;
        logic [8:0]  col;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            li = 3'($urandom_range(0, N_LINES - 1));
            cp = 5'($urandom_range(0, N_CHARS - 1));
            if ($urandom_range(0, 19) == 0)
            begin
                li = 3'($urandom);
                cp = 5'($urandom);
            end
            send_cell(li, cp, random_code());
        end
        else if (pick < 18)
        begin
            li = ($urandom_range(0, 19) == 0) ? 3'($urandom) : 3'($urandom_range(0, N_LINES - 1));
            len = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(18, 31));
            send_line(li, len, 16'($urandom));
        end
        else if (pick < 21)
            send_item(tovl_pkg::OP_IDLE, 3'($urandom), 5'($urandom), 7'($urandom),
                      5'($urandom), 16'($urandom), 8'($urandom), 9'($urandom));
        else if (page_sel)
        begin
            // Aim most status pixels into the text bands, where the glyph logic is exercised.
            if ($urandom_range(0, 3) != 0)
            begin
                ln = $urandom_range(0, N_LINES - 1);
                s = (ln == N_LINES - 1) ? 1 : 2;
                row = 8'(text_top(ln) + $urandom_range(0, 7 * s - 1));
            end
            else
                row = 8'($urandom);
            col = ($urandom_range(0, 6) != 0) ? 9'($urandom_range(TEXT_LEFT, SCREEN_W - 1))
                                              : 9'($urandom);
            send_pixel(row, col);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: row = 8'($urandom_range(SCREEN_H - 2, 255));
                1: row = 8'($urandom);
                default: row = 8'($urandom_range(0, SCREEN_H - 1));
            endcase
            case ($urandom_range(0, 4))
                0: col = 9'($urandom_range(IMG_X0 - 2, IMG_X0 + 1));
                1: col = 9'($urandom_range(IMG_X0 + IMG_W - 2, IMG_X0 + IMG_W + 1));
                2: col = 9'($urandom);
                default: col = 9'($urandom_range(0, SCREEN_W - 1));
            endcase
            send_pixel(row, col);
        end
    endtask

    // Every cell gets a code up front, so no pixel can ever read an unwritten cell.
    task automatic preload_char_store();
        for (int ln = 0; ln < N_LINES; ln++)
            for (int cp = 0; cp < N_CHARS; cp++)
                send_cell(3'(ln), 5'(cp), random_code());
    endtask

    task automatic test_reset_values();
        send_pixel(8'd0, 9'd0);
        send_pixel(8'd0, 9'(IMG_X0));
        send_pixel(8'(SCREEN_H - 1), 9'(IMG_X0 + IMG_W - 1));
        send_pixel(8'(SCREEN_H - 1), 9'(IMG_X0 + IMG_W));
        send_pixel(8'(SCREEN_H), 9'd100);
        send_pixel(8'hFF, 9'h1FF);
        send_item(tovl_pkg::OP_IDLE, 3'h7, 5'h1F, 7'h7F, 5'h1F, 16'hFFFF, 8'hFF, 9'h1FF);
        write_register(tovl_pkg::CFG_PAGE_SELECT, 16'h0001);
        send_pixel(8'd12, 9'd12);
    endtask

    task automatic test_text_rendering();
        send_cell(3'd0, 5'd0, 7'd65);
        send_cell(3'd0, 5'd1, 7'd48);
        send_cell(3'd0, 5'd2, 7'd32);
        send_cell(3'd0, 5'd3, 7'd97);
        send_cell(3'd0, 5'd24, 7'd72);
        send_cell(3'd0, 5'd25, 7'd72);
        send_line(3'd0, 5'd27, 16'hF800);
        // Writes that address past the stores must leave them alone.
        send_cell(3'd7, 5'd0, 7'd72);
        send_cell(3'd0, 5'd27, 7'd72);
        send_line(3'd7, 5'd5, 16'h1234);
        send_cell(3'd6, 5'd0, 7'd65);
        send_line(3'd6, 5'd31, 16'h07E0);
        send_pixel(8'd12, 9'd12);
        send_pixel(8'd23, 9'd21);
        send_pixel(8'd12, 9'd24);
        send_pixel(8'd12, 9'd38);
        send_pixel(8'd12, 9'd48);
        send_pixel(8'd12, 9'd300);
        send_pixel(8'd12, 9'd312);
        send_pixel(8'd221, 9'd12);
        send_pixel(8'd221, 9'd17);
    endtask

    task automatic test_random_phase(input logic page, input logic [15:0] bg,
                                     input logic [15:0] margin, input bit calm, input int count);
        write_register(tovl_pkg::CFG_PAGE_SELECT, {15'($urandom), page});
        write_register(tovl_pkg::CFG_BACKGROUND, bg);
        write_register(tovl_pkg::CFG_MARGIN, margin);
        calm_mode = calm;
        if (page)
            for (int ln = 0; ln < N_LINES; ln++)
                send_line(3'(ln), 5'($urandom_range(10, 31)), 16'($urandom));
        repeat (count) send_random_item();
        calm_mode = 1'b0;
    endtask

    initial
    begin : result_sink
        int hold;
        hold = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                result_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    task automatic log_mismatch(input string what, input pixel_result_t want,
                                input pixel_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: want v=%0b c=%h i=%0b a=%0d, got v=%0b c=%h i=%0b a=%0d",
                     $realtime, what, want.pixel_valid, want.color, want.use_image, want.address,
                     got.pixel_valid, got.color, got.use_image, got.address);
    endtask

    always @(posedge clk)
    begin
        pixel_result_t got;
        pixel_result_t want;
        if (rst_n)
        begin
            if ((request_ch.valid === 1'b1 && request_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got.pixel_valid = result_ch.pixel_valid;
                got.color       = result_ch.pixel_color;
                got.use_image   = result_ch.use_image;
                got.address     = result_ch.image_address;
                if (expected_pixels.size() == 0)
                    log_mismatch("result with no transaction pending", '0, got);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.pixel_valid !== want.pixel_valid || got.color !== want.color ||
                        got.use_image !== want.use_image || got.address !== want.address)
                        log_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        request_ch.valid         = 1'b0;
        request_ch.opcode        = tovl_pkg::OP_IDLE;
        request_ch.line_index    = 3'd0;
        request_ch.char_position = 5'd0;
        request_ch.char_code     = 7'd0;
        request_ch.line_length   = 5'd0;
        request_ch.line_color    = 16'h0000;
        request_ch.pixel_row     = 8'd0;
        request_ch.pixel_column  = 9'd0;
        for (int ln = 0; ln < N_LINES; ln++)
        begin
            line_len[ln] = 5'd0;
            line_rgb[ln] = 16'h0000;
            for (int cp = 0; cp < N_CHARS; cp++)
                cell_mem[ln][cp] = 7'd0;
        end
        page_sel   = 1'b0;
        back_rgb   = 16'h18E3;
        margin_rgb = 16'hFFFF;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        preload_char_store();
        test_reset_values();
        test_text_rendering();
        test_random_phase(1'b1, 16'h0000, 16'($urandom), 1'b1, 185);
        test_random_phase(1'b1, 16'hFFFF, 16'h0000, 1'b0, 185);
        test_random_phase(1'b0, 16'($urandom), 16'h0000, 1'b0, 185);
        test_random_phase(1'b1, 16'($urandom), 16'($urandom), 1'b0, 185);
        test_random_phase(1'b0, 16'($urandom), 16'($urandom), 1'b0, 185);
        test_random_phase(1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 185);

        @(negedge clk);
        request_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tovl_pkg.sv
rtl/core/tovl_req_if.sv
rtl/core/tovl_rsp_if.sv
rtl/core/tovl_locate.sv
rtl/core/tovl_divide.sv
rtl/core/tovl_fetch.sv
rtl/core/tovl_shade.sv
rtl/core/text_overlay_pixel_generator.sv
bench/tb_top.sv
